>>> sv/tef_pkg.sv
`default_nettype none

package tef_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int DEV_W = 32;

    localparam logic [2:0] KIND_SET_INTEGRITY = 3'd0;
    localparam logic [2:0] KIND_FREE          = 3'd1;
    localparam logic [2:0] KIND_EXEC          = 3'd2;
    localparam logic [2:0] KIND_MMAP          = 3'd3;
    localparam logic [2:0] KIND_MPROTECT      = 3'd4;

    localparam logic [1:0] ITYPE_SIG_VALID = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_FREE,
        OP_LOOKUP
    } t_op;

    typedef struct packed {
        logic             ins;
        logic             clr;
        logic [IDX_W-1:0] addr;
        logic [DEV_W-1:0] dev;
        logic             sig;
    } t_tbl_wr;

    typedef struct packed {
        logic             in_use;
        logic [DEV_W-1:0] dev;
        logic             sig;
    } t_tbl_rd;

    typedef struct packed {
        logic valid;
        logic deny;
        logic full;
    } t_result;

endpackage

`default_nettype wire

>>> sv/tef_table.sv
`default_nettype none

module tef_table
    import tef_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_tbl_rd               o_rd,
    input  t_tbl_wr               i_wr
);

    logic [DEV_W:0]         r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_use;
    logic [DEV_W:0]         r_rd_ent;
    logic                   r_rd_use;

    always_ff @(posedge i_clk) begin
        if (i_wr.ins) begin
            r_mem[i_wr.addr] <= {i_wr.dev, i_wr.sig};
        end
        if (i_rd_en) begin
            r_rd_ent <= r_mem[i_rd_addr];
            r_rd_use <= r_use[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
        end else begin
            if (i_wr.ins) begin
                r_use[i_wr.addr] <= 1'b1;
            end
            if (i_wr.clr) begin
                r_use[i_wr.addr] <= 1'b0;
            end
        end
    end

    assign o_rd = '{in_use: r_rd_use, dev: r_rd_ent[DEV_W:1], sig: r_rd_ent[0]};

endmodule

`default_nettype wire

>>> sv/tef_ctrl.sv
`default_nettype none

module tef_ctrl
    import tef_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [2:0]       i_kind,
    input  wire logic [DEV_W-1:0] i_device,
    input  wire logic [1:0]       i_integrity_type,
    input  wire logic             i_has_signature_data,
    input  wire logic             i_exec_req,
    input  wire logic             i_already_executable,
    input  wire logic             i_has_file,
    input  wire logic [DEV_W-1:0] i_initramfs,
    input  wire logic             i_res_ready,
    output logic                  o_busy,
    output logic                  o_rd_en,
    output logic [IDX_W-1:0]      o_rd_addr,
    input  t_tbl_rd               i_rd,
    output t_tbl_wr               o_wr,
    output t_result               o_res
);

    t_state r_state, n_state;

    t_op              r_op, n_op;
    logic             r_deny_fix, n_deny_fix;
    logic [DEV_W-1:0] r_dev;
    logic             r_sig;

    logic [CNT_W-1:0] r_rd_cnt;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_hit_sig;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free_idx;

    logic skip;
    logic init_hit;
    logic last_cmp;

    // decode the incoming item into a table operation
    always_comb begin
        skip     = ((i_kind != KIND_EXEC) && !i_exec_req)
                   || ((i_kind == KIND_MPROTECT) && i_already_executable);
        init_hit = (i_initramfs != '0) && (i_device == i_initramfs);
        n_op       = OP_NONE;
        n_deny_fix = 1'b0;
        unique case (i_kind) inside
            KIND_SET_INTEGRITY: begin
                if (i_integrity_type == ITYPE_SIG_VALID) begin
                    n_op = OP_INSERT;
                end
            end
            KIND_FREE: n_op = OP_FREE;
            KIND_EXEC, KIND_MMAP, KIND_MPROTECT: begin
                if (!skip) begin
                    if (!i_has_file) begin
                        n_deny_fix = 1'b1;
                    end else if (!init_hit) begin
                        n_op = OP_LOOKUP;
                    end
                end
            end
            default: n_op = OP_NONE;
        endcase
    end

    assign last_cmp = r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_ENTRIES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = (n_op == OP_NONE) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_cmp) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy    = (r_state != ST_IDLE);
        o_rd_en   = 1'b0;
        o_rd_addr = r_rd_cnt[IDX_W-1:0];
        o_wr      = '0;
        o_res     = '0;
        unique case (r_state)
            ST_IDLE: ;
            ST_SCAN: o_rd_en = (r_rd_cnt < CNT_W'(TABLE_ENTRIES));
            ST_DONE: begin
                o_res.valid = i_res_ready;
                o_res.deny  = (r_op == OP_LOOKUP) ? !(r_found && r_hit_sig) : r_deny_fix;
                o_res.full  = (r_op == OP_INSERT) && !r_found && !r_free_ok;
                o_wr.dev    = r_dev;
                o_wr.sig    = r_sig;
                o_wr.addr   = r_found ? r_hit_idx : r_free_idx;
                o_wr.ins    = i_res_ready && (r_op == OP_INSERT) && (r_found || r_free_ok);
                o_wr.clr    = i_res_ready && (r_op == OP_FREE) && r_found;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= o_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_accept) begin
            r_op       <= n_op;
            r_deny_fix <= n_deny_fix;
            r_dev      <= i_device;
            r_sig      <= i_has_signature_data;
            r_rd_cnt   <= '0;
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
        end else begin
            if (o_rd_en) begin
                r_rd_cnt  <= r_rd_cnt + CNT_W'(1);
                r_cmp_idx <= r_rd_cnt[IDX_W-1:0];
            end
            // first matching entry wins; remember the lowest free slot on the way
            if (r_cmp_vld) begin
                if (i_rd.in_use && (i_rd.dev == r_dev) && !r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_hit_sig <= i_rd.sig;
                end
                if (!i_rd.in_use && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/trusted_exec_device_filter.sv
// Trusted-execution device filter.
// Input channel: i_in_valid / o_in_stall carries one event (set integrity,
// free device, exec / mmap / mprotect check) per transfer. Output channel:
// o_out_valid / i_out_stall carries one result (deny, table_full) per event.
// The initramfs device register is written with i_cfg_we / i_cfg_wdata.
// Device entries live in a single-port-read synchronous RAM of
// TABLE_ENTRIES words; the in-use bits sit in flip-flops next to it.
// An event that touches the table (insert, free, or a check that needs the
// table) scans every entry, one RAM read per cycle, then enters the done
// state, from which its result moves into the output register.
// Events decided without the table go from idle straight to the done state.
// One event is in flight at a time; o_in_stall is high until its result
// has moved into the output register, so the next event can be taken
// while that result still waits on a stalled receiver.
// Reset (synchronous, active low) empties the table, clears the initramfs
// register and drops any pending result. While i_out_stall is high with a
// result held, the output holds; a finished event delays its table write.
`default_nettype none

module trusted_exec_device_filter
    import tef_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [DEV_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [2:0]       i_kind,
    input  wire logic [DEV_W-1:0] i_device,
    input  wire logic [1:0]       i_integrity_type,
    input  wire logic             i_has_signature_data,
    input  wire logic             i_exec_req,
    input  wire logic             i_already_executable,
    input  wire logic             i_has_file,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_deny,
    output logic                  o_table_full
);

    logic [DEV_W-1:0] r_initramfs;
    logic             r_out_valid;
    logic             r_deny;
    logic             r_full;

    logic             busy;
    logic             res_ready;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_tbl_rd          rd;
    t_tbl_wr          wr;
    t_result          res;

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initramfs <= '0;
        end else if (i_cfg_we) begin
            r_initramfs <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_deny <= res.deny;
            r_full <= res.full;
        end
    end

    tef_ctrl u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (i_in_valid && !busy),
        .i_kind               (i_kind),
        .i_device             (i_device),
        .i_integrity_type     (i_integrity_type),
        .i_has_signature_data (i_has_signature_data),
        .i_exec_req           (i_exec_req),
        .i_already_executable (i_already_executable),
        .i_has_file           (i_has_file),
        .i_initramfs          (r_initramfs),
        .i_res_ready          (res_ready),
        .o_busy               (busy),
        .o_rd_en              (rd_en),
        .o_rd_addr            (rd_addr),
        .i_rd                 (rd),
        .o_wr                 (wr),
        .o_res                (res)
    );

    tef_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_wr      (wr)
    );

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_deny       = r_deny;
    assign o_table_full = r_full;

endmodule

`default_nettype wire

>>> sv/tef_checker.sv
`default_nettype none

module tef_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_deny,
    input wire logic o_table_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_deny) && $stable(o_table_full))
        else $error("stalled result changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second event taken while one is in flight");

    a_full_no_deny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_deny && o_table_full))
        else $error("deny and table_full on one result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left a result or busy state");

endmodule

bind trusted_exec_device_filter tef_checker u_tef_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_deny       (o_deny),
    .o_table_full (o_table_full)
);

`default_nettype wire

>>> verif/trusted_exec_device_filter_test.sv
`default_nettype none

module trusted_exec_device_filter_test
    import tef_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 800_000;
    localparam int TAIL_CYCLES = 2 * (TABLE_ENTRIES + 3);
    localparam int POOL_SIZE   = 96;
    localparam int MAX_WAIT    = 14;

    // Kinds above mprotect are reserved; integrity types other than
    // signature-valid leave the table alone.
    localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
    localparam logic [1:0] ITYPE_ALT1      = 2'd1;
    localparam logic [1:0] ITYPE_ALT2      = 2'd2;
    localparam logic [1:0] ITYPE_RSVD      = 2'd3;

    typedef struct {
        logic [2:0]       kind;
        logic [DEV_W-1:0] dev;
        logic [1:0]       itype;
        logic             sig;
        logic             exec_req;
        logic             already_exec;
        logic             has_file;
    } t_event;

    typedef struct {
        logic deny;
        logic full;
    } t_verdict;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DEV_W-1:0] i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [2:0]       i_kind;
    logic [DEV_W-1:0] i_device;
    logic [1:0]       i_integrity_type;
    logic             i_has_signature_data;
    logic             i_exec_req;
    logic             i_already_executable;
    logic             i_has_file;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_deny;
    logic             o_table_full;

    trusted_exec_device_filter dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_kind               (i_kind),
        .i_device             (i_device),
        .i_integrity_type     (i_integrity_type),
        .i_has_signature_data (i_has_signature_data),
        .i_exec_req           (i_exec_req),
        .i_already_executable (i_already_executable),
        .i_has_file           (i_has_file),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_deny               (o_deny),
        .o_table_full         (o_table_full)
    );

    // Shadow of the device table and the initramfs register
    logic [DEV_W-1:0] tbl_dev  [TABLE_ENTRIES];
    logic             tbl_sig  [TABLE_ENTRIES];
    logic             tbl_used [TABLE_ENTRIES];
    logic [DEV_W-1:0] initramfs_dev;

    t_verdict         pending_verdicts [$];
    logic [DEV_W-1:0] dev_pool [POOL_SIZE];
    int               fail_count;
    int               tx_gap_max;
    int               rx_wait_max;
    int               rx_hold;
    int               cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int find_slot(input logic [DEV_W-1:0] dev);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_used[i] && tbl_dev[i] == dev) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int table_load();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n += int'(tbl_used[i]);
        end
        return n;
    endfunction

    // Apply one event to the shadow table and return the verdict it yields.
    function automatic t_verdict predict_verdict(input t_event ev);
        t_verdict v;
        int       slot;
        logic     skip;
        logic     trusted;
        v.deny = 1'b0;
        v.full = 1'b0;
        case (ev.kind) inside
            KIND_SET_INTEGRITY: begin
                if (ev.itype == ITYPE_SIG_VALID) begin
                    slot = find_slot(ev.dev);
                    // new device: take the lowest free entry
                    for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
                        if (!tbl_used[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        v.full = 1'b1;
                    end else begin
                        tbl_dev[slot]  = ev.dev;
                        tbl_sig[slot]  = ev.sig;
                        tbl_used[slot] = 1'b1;
                    end
                end
            end
            KIND_FREE: begin
                slot = find_slot(ev.dev);
                if (slot >= 0) begin
                    tbl_used[slot] = 1'b0;
                end
            end
            KIND_EXEC, KIND_MMAP, KIND_MPROTECT: begin
                skip = (ev.kind != KIND_EXEC && !ev.exec_req) ||
                       (ev.kind == KIND_MPROTECT && ev.already_exec);
                if (!skip) begin
                    slot    = find_slot(ev.dev);
                    trusted = (initramfs_dev != '0 && ev.dev == initramfs_dev) ||
                              (slot >= 0 && tbl_sig[slot]);
                    v.deny  = !ev.has_file || !trusted;
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic t_event mk_event(input logic [2:0] kind, input logic [DEV_W-1:0] dev,
                                        input logic [1:0] itype, input logic sig,
                                        input logic exec_req, input logic already_exec,
                                        input logic has_file);
        t_event ev;
        ev.kind         = kind;
        ev.dev          = dev;
        ev.itype        = itype;
        ev.sig          = sig;
        ev.exec_req     = exec_req;
        ev.already_exec = already_exec;
        ev.has_file     = has_file;
        return ev;
    endfunction

    // Random event; ins_pct and free_pct steer how full the table gets.
    function automatic t_event random_event(input int ins_pct, input int free_pct);
        t_event ev;
        int     r;
        r = $urandom_range(0, 99);
        ev.dev          = ($urandom_range(0, 19) == 0) ? $urandom()
                                                      : dev_pool[$urandom_range(0, POOL_SIZE - 1)];
        ev.itype        = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(ITYPE_ALT1, ITYPE_RSVD))
                                                      : ITYPE_SIG_VALID;
        ev.sig          = 1'($urandom_range(0, 1));
        ev.exec_req     = $urandom_range(0, 3) != 0;
        ev.already_exec = $urandom_range(0, 3) == 0;
        ev.has_file     = $urandom_range(0, 7) != 0;
        if (r < ins_pct) begin
            ev.kind = KIND_SET_INTEGRITY;
        end else if (r < ins_pct + free_pct) begin
            ev.kind = KIND_FREE;
        end else if (r < 96) begin
            ev.kind = 3'($urandom_range(KIND_EXEC, KIND_MPROTECT));
        end else begin
            ev.kind = 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
        end
        return ev;
    endfunction

    // Offer one event; valid stays high after the transfer so that a
    // back-to-back event needs no second assignment in the same step.
    task automatic send_event(input t_event ev);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_kind               <= ev.kind;
        i_device             <= ev.dev;
        i_integrity_type     <= ev.itype;
        i_has_signature_data <= ev.sig;
        i_exec_req           <= ev.exec_req;
        i_already_executable <= ev.already_exec;
        i_has_file           <= ev.has_file;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_verdicts.push_back(predict_verdict(ev));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_initramfs(input logic [DEV_W-1:0] dev);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dev;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        initramfs_dev  = dev;
    endtask

    task automatic test_checks_without_table();
        set_initramfs('0);
        send_event(mk_event(KIND_EXEC, 32'h0000_1234, ITYPE_SIG_VALID, 0, 1, 0, 0));
        send_event(mk_event(KIND_EXEC, '0, ITYPE_SIG_VALID, 0, 1, 0, 1));
        send_event(mk_event(KIND_EXEC, 32'h0BAD_F00D, ITYPE_SIG_VALID, 0, 0, 1, 1));
        send_event(mk_event(KIND_MMAP, '1, ITYPE_RSVD, 1, 0, 1, 0));
        send_event(mk_event(KIND_MMAP, '1, ITYPE_SIG_VALID, 0, 1, 0, 0));
        send_event(mk_event(KIND_MPROTECT, '1, ITYPE_SIG_VALID, 0, 1, 1, 0));
        send_event(mk_event(KIND_MPROTECT, '0, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_MPROTECT, '1, ITYPE_SIG_VALID, 1, 1, 0, 1));
        for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++) begin
            send_event(mk_event(3'(k), '1, ITYPE_RSVD, 1, 1, 1, 1));
        end
        wait_idle();
    endtask

    task automatic test_integrity_events();
        logic [DEV_W-1:0] dev_a;
        dev_a = 32'hA5A5_0F0F;
        send_event(mk_event(KIND_SET_INTEGRITY, dev_a, ITYPE_ALT1, 1, 0, 0, 0));
        send_event(mk_event(KIND_SET_INTEGRITY, dev_a, ITYPE_ALT2, 1, 0, 0, 0));
        send_event(mk_event(KIND_SET_INTEGRITY, dev_a, ITYPE_RSVD, 1, 1, 1, 1));
        send_event(mk_event(KIND_EXEC, dev_a, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_SET_INTEGRITY, dev_a, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, dev_a, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_MMAP, dev_a, ITYPE_SIG_VALID, 0, 1, 0, 1));
        // overwrite clears the signature bit
        send_event(mk_event(KIND_SET_INTEGRITY, dev_a, ITYPE_SIG_VALID, 0, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, dev_a, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_SET_INTEGRITY, dev_a, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_FREE, dev_a, ITYPE_SIG_VALID, 0, 0, 0, 0));
        send_event(mk_event(KIND_MPROTECT, dev_a, ITYPE_SIG_VALID, 0, 1, 0, 1));
        send_event(mk_event(KIND_FREE, dev_a, ITYPE_SIG_VALID, 0, 0, 0, 0));
        send_event(mk_event(KIND_SET_INTEGRITY, '0, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, '0, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_SET_INTEGRITY, '1, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_MPROTECT, '1, ITYPE_SIG_VALID, 0, 1, 0, 1));
        wait_idle();
    endtask

    task automatic test_initramfs_trust();
        set_initramfs('1);
        send_event(mk_event(KIND_FREE, '1, ITYPE_SIG_VALID, 0, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, '1, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_EXEC, 32'hFFFF_FFFE, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_MMAP, '1, ITYPE_SIG_VALID, 0, 1, 0, 0));
        wait_idle();
        set_initramfs('0);
        send_event(mk_event(KIND_EXEC, '0, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_FREE, '0, ITYPE_SIG_VALID, 0, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, '0, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_EXEC, '1, ITYPE_SIG_VALID, 0, 0, 0, 1));
        wait_idle();
        set_initramfs(32'h0000_0004);
        send_event(mk_event(KIND_EXEC, 32'h0000_0004, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_MPROTECT, 32'h0000_0004, ITYPE_SIG_VALID, 0, 1, 0, 1));
        send_event(mk_event(KIND_EXEC, 32'h0000_0004, ITYPE_SIG_VALID, 0, 0, 0, 0));
        wait_idle();
    endtask

    task automatic test_table_full();
        logic [DEV_W-1:0] fresh;
        logic [DEV_W-1:0] dropped;
        int               slot;
        set_initramfs('0);
        while (table_load() < TABLE_ENTRIES) begin
            do fresh = $urandom(); while (find_slot(fresh) >= 0);
            send_event(mk_event(KIND_SET_INTEGRITY, fresh, ITYPE_SIG_VALID,
                                1'($urandom_range(0, 1)), 0, 0, 0));
        end
        do dropped = $urandom(); while (find_slot(dropped) >= 0);
        send_event(mk_event(KIND_SET_INTEGRITY, dropped, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, dropped, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_FREE, dropped, ITYPE_SIG_VALID, 0, 0, 0, 0));
        // overwrite while full must not report full
        slot = $urandom_range(0, TABLE_ENTRIES - 1);
        fresh = tbl_dev[slot];
        send_event(mk_event(KIND_SET_INTEGRITY, fresh, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_EXEC, fresh, ITYPE_SIG_VALID, 0, 0, 0, 1));
        send_event(mk_event(KIND_FREE, fresh, ITYPE_SIG_VALID, 0, 0, 0, 0));
        send_event(mk_event(KIND_SET_INTEGRITY, dropped, ITYPE_SIG_VALID, 1, 0, 0, 0));
        send_event(mk_event(KIND_MMAP, dropped, ITYPE_SIG_VALID, 0, 1, 0, 1));
        // empty the table again for the random traffic
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_used[i]) begin
                send_event(mk_event(KIND_FREE, tbl_dev[i], ITYPE_SIG_VALID, 0, 0, 0, 0));
            end
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        tx_gap_max = 0;
        rx_hold    = 300;
        for (int n = 0; n < 8; n++) begin
            send_event(random_event(40, 20));
        end
        wait_idle();
        tx_gap_max = MAX_WAIT;
    endtask

    task automatic test_random_traffic();
        int ins_pct;
        int free_pct;
        for (int round = 0; round < 8; round++) begin
            wait_idle();
            case (round % 4)
                0: set_initramfs('0);
                1: set_initramfs('1);
                2: set_initramfs(dev_pool[$urandom_range(0, POOL_SIZE - 1)]);
                default: set_initramfs($urandom());
            endcase
            case (round % 3)
                0: begin ins_pct = 60; free_pct = 10; end
                1: begin ins_pct = 20; free_pct = 40; end
                default: begin ins_pct = 40; free_pct = 20; end
            endcase
            tx_gap_max  = (round == 2) ? 0 : MAX_WAIT;
            rx_wait_max = (round == 2 || round == 5) ? 0 : MAX_WAIT;
            for (int n = 0; n < 130; n++) begin
                // pause the sender until every result is back
                if (round == 3 && n == 65) begin
                    wait_idle();
                end
                send_event(random_event(ins_pct, free_pct));
            end
        end
        wait_idle();
        tx_gap_max  = MAX_WAIT;
        rx_wait_max = MAX_WAIT;
    endtask

    // Output side: draw a wait after each transfer, plus any long hold.
    initial begin
        int rx_wait;
        rx_wait      = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                rx_wait = $urandom_range(0, rx_wait_max);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_hold > 0) begin
                rx_hold--;
            end
            i_out_stall <= (rx_wait > 0) || (rx_hold > 0);
        end
    end

    initial begin
        t_verdict want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_verdicts.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected: deny %b table_full %b",
                             $time, o_deny, o_table_full);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_deny !== want.deny) begin
                        fail_count++;
                        $display("%0t: deny mismatch: expected %b, actual %b",
                                 $time, want.deny, o_deny);
                    end
                    if (o_table_full !== want.full) begin
                        fail_count++;
                        $display("%0t: table_full mismatch: expected %b, actual %b",
                                 $time, want.full, o_table_full);
                    end
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        fail_count            = 0;
        tx_gap_max            = MAX_WAIT;
        rx_wait_max           = MAX_WAIT;
        rx_hold               = 0;
        initramfs_dev         = '0;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_wdata          <= '0;
        i_in_valid           <= 1'b0;
        i_kind               <= KIND_SET_INTEGRITY;
        i_device             <= '0;
        i_integrity_type     <= ITYPE_SIG_VALID;
        i_has_signature_data <= 1'b0;
        i_exec_req           <= 1'b0;
        i_already_executable <= 1'b0;
        i_has_file           <= 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_dev[i]  = '0;
            tbl_sig[i]  = 1'b0;
            tbl_used[i] = 1'b0;
        end
        dev_pool[0] = '0;
        dev_pool[1] = '1;
        dev_pool[2] = 32'h0000_0004;
        for (int i = 3; i < POOL_SIZE; i++) begin
            dev_pool[i] = $urandom();
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_checks_without_table();
        test_integrity_events();
        test_initramfs_trust();
        test_table_full();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
